### rtl/base64_stream_codec_defines.svh
// Assertion macros for the base64 stream codec.
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

// Same-cycle implication.
`define B64SC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("b64sc assertion failed");

// Next-cycle implication.
`define B64SC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("b64sc assertion failed");

`endif

### rtl/b64sc_pkg.sv
package b64sc_pkg;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    localparam logic [7:0] PAD_CHAR = 8'h3D; // '='
    localparam int         MAX_RESULTS = 4;

    typedef struct packed {
        logic [17:0] bits;
        logic [1:0]  count;
        logic        stopped;
    } state_t;

    typedef struct packed {
        logic [2:0]                    num;
        logic [MAX_RESULTS-1:0][7:0]   bytes;   // bytes[0] goes out first
        logic                          stream_end;
    } result_t;

    // Sextet to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        c = 8'h00;
        if (s < 6'd26) begin
            c = {2'b00, s} + 8'h41;
        end else if (s < 6'd52) begin
            c = {2'b00, s} + 8'h47;          // 'a' - 26
        end else if (s < 6'd62) begin
            c = {2'b00, s} - 8'h04;          // '0' - 52
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Alphabet character to {valid, sextet}.
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h47)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c + 8'h04)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

### rtl/base64_stream_codec.sv
// Base64 stream codec (standard alphabet). cfg_data selects the direction:
// 0 encodes bytes to text, 1 decodes text to bytes; a write also drops any
// partial group. Each request is registered and then processed
// combinationally into a result buffer that streams one byte per cycle on
// the m_ side while m_tready is high, so the rate is set by that output
// port: a new request is processed only once the buffer is empty or its
// last byte is leaving. s_tlast flushes the stream; m_tlast marks the last
// byte of each request, m_tuser the last byte of the stream. Decoding stops
// at the first '=' or foreign character.
`include "base64_stream_codec_defines.svh"

module base64_stream_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,   // direction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    input  logic        s_tlast,    // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic        m_tlast,    // run_last
    output logic [0:0]  m_tuser     // [0] stream_end
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    b64sc_pkg::dir_t    dir_reg;
    b64sc_pkg::state_t  state_reg;
    b64sc_pkg::state_t  state_next;
    b64sc_pkg::result_t res;
    logic               buf_free;
    logic               step_go;
    logic               cfg_go;

    assign cfg_ready = 1'b1;
    assign cfg_go    = cfg_valid && cfg_ready;
    assign step_go   = in_valid_reg && buf_free;
    assign s_tready  = !in_valid_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg   <= b64sc_pkg::DIR_ENCODE;
            state_reg <= '0;
        end else if (cfg_go) begin
            dir_reg   <= b64sc_pkg::dir_t'(cfg_data);
            state_reg <= '0;
        end else if (step_go) begin
            state_reg <= state_next;
        end
    end

    b64sc_step u_step (
        .dir     (dir_reg),
        .st      (state_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .st_next (state_next),
        .res     (res)
    );

    b64sc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_go),
        .res      (res),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `B64SC_ASSERT_NOW(a_end_on_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    `B64SC_ASSERT_NEXT(a_res_shown, aclk, aresetn, step_go && res.num != 3'd0, m_tvalid)
    `B64SC_ASSERT_NEXT(a_cfg_clears, aclk, aresetn, cfg_go, state_reg.count == 2'd0)
    `B64SC_ASSERT_NOW(a_enc_groups, aclk, aresetn,
        step_go && dir_reg == b64sc_pkg::DIR_ENCODE, res.num == 3'd0 || res.num == 3'd4)

endmodule

### rtl/b64sc_step.sv
module b64sc_step (
    input  b64sc_pkg::dir_t    dir,
    input  b64sc_pkg::state_t  st,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output b64sc_pkg::state_t  st_next,
    output b64sc_pkg::result_t res
);

    logic [6:0]  sx;
    logic [23:0] word;

    always_comb begin
        sx      = b64sc_pkg::dec_sextet(in_byte);
        word    = '0;
        st_next = st;
        res     = '0;

        if (dir == b64sc_pkg::DIR_ENCODE) begin
            if (st.count == 2'd2) begin
                word         = {st.bits[15:0], in_byte};
                res.num      = 3'd4;
                res.bytes[0] = b64sc_pkg::enc_char(word[23:18]);
                res.bytes[1] = b64sc_pkg::enc_char(word[17:12]);
                res.bytes[2] = b64sc_pkg::enc_char(word[11:6]);
                res.bytes[3] = b64sc_pkg::enc_char(word[5:0]);
                st_next.bits  = '0;
                st_next.count = 2'd0;
            end else begin
                st_next.bits  = {st.bits[9:0], in_byte};
                st_next.count = st.count + 2'd1;
                if (in_last) begin
                    // flush partial group with padding
                    if (st_next.count == 2'd1) begin
                        word = {st_next.bits[7:0], 16'h0000};
                    end else begin
                        word = {st_next.bits[15:0], 8'h00};
                    end
                    res.num      = 3'd4;
                    res.bytes[0] = b64sc_pkg::enc_char(word[23:18]);
                    res.bytes[1] = b64sc_pkg::enc_char(word[17:12]);
                    res.bytes[2] = (st_next.count == 2'd1) ? b64sc_pkg::PAD_CHAR
                                                           : b64sc_pkg::enc_char(word[11:6]);
                    res.bytes[3] = b64sc_pkg::PAD_CHAR;
                end
            end
        end else begin
            if (!st.stopped) begin
                if (!sx[6]) begin
                    st_next.stopped = 1'b1;
                end else if (st.count == 2'd3) begin
                    word         = {st.bits, sx[5:0]};
                    res.num      = 3'd3;
                    res.bytes[0] = word[23:16];
                    res.bytes[1] = word[15:8];
                    res.bytes[2] = word[7:0];
                    st_next.bits  = '0;
                    st_next.count = 2'd0;
                end else begin
                    st_next.bits  = {st.bits[11:0], sx[5:0]};
                    st_next.count = st.count + 2'd1;
                end
            end
            if (in_last && st_next.count == 2'd2) begin
                res.num      = 3'd1;
                res.bytes[0] = st_next.bits[11:4];
            end else if (in_last && st_next.count == 2'd3) begin
                res.num      = 3'd2;
                res.bytes[0] = st_next.bits[17:10];
                res.bytes[1] = st_next.bits[9:2];
            end
        end

        res.stream_end = in_last;
        if (in_last) begin
            st_next = '0;
        end
    end

endmodule

### rtl/b64sc_out.sv
module b64sc_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  b64sc_pkg::result_t  res,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // out_byte
    output logic                m_tlast,   // run_last
    output logic [0:0]          m_tuser    // [0] stream_end
);

    logic [2:0]                                cnt_reg;
    logic [b64sc_pkg::MAX_RESULTS-1:0][7:0]    bytes_reg;
    logic                                      end_reg;
    logic                                      take;

    assign m_tvalid = (cnt_reg != 3'd0);
    assign take     = m_tvalid && m_tready;
    assign free     = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tuser  = (cnt_reg == 3'd1) && end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else if (load) begin
            cnt_reg <= res.num;
        end else if (take) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= res.bytes;
            end_reg   <= res.stream_end;
        end else if (take) begin
            bytes_reg <= {8'h00, bytes_reg[b64sc_pkg::MAX_RESULTS-1:1]};
        end
    end

endmodule

### tb/sv/tb_base64_stream_codec.sv
module tb_base64_stream_codec;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } out_req_t;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    // codec state as the stimulus side sees it
    b64sc_pkg::dir_t cur_dir  = b64sc_pkg::DIR_ENCODE;
    logic [17:0]     grp_bits = '0;
    logic [1:0]      grp_cnt  = '0;
    logic            dec_halt = 1'b0;

    in_req_t  in_bytes_todo[$];
    out_req_t out_bytes_due[$];

    int src_gap   = 0;
    int sink_gap  = 0;
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int errors    = 0;

    base64_stream_codec i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] in_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] out_byte
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)    // [0] stream_end
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        return ALPHABET[(63 - int'(s)) * 8 +: 8];
    endfunction

    // {hit, sextet}
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[(63 - i) * 8 +: 8] == c) return {1'b1, 6'(i)};
        end
        return 7'h00;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic b64_transcode(input logic [7:0] b, input logic last);
        logic [7:0]  res[4];
        logic [23:0] word;
        logic [6:0]  sx;
        out_req_t    o;
        int          n;
        n = 0;
        if (cur_dir == b64sc_pkg::DIR_ENCODE) begin
            if (grp_cnt == 2) begin
                word = {grp_bits[15:0], b};
                for (int i = 0; i < 4; i++) begin
                    res[n] = sextet_char(word[18 - 6 * i +: 6]);
                    n = n + 1;
                end
                grp_bits = '0;
                grp_cnt  = '0;
            end else begin
                grp_bits = {grp_bits[9:0], b};
                grp_cnt  = grp_cnt + 2'd1;
            end
            if (last && grp_cnt != 0) begin
                word = (grp_cnt == 1) ? {grp_bits[7:0], 16'h0000} : {grp_bits[15:0], 8'h00};
                for (int i = 0; i < 4; i++) begin
                    res[n] = (i <= int'(grp_cnt)) ? sextet_char(word[18 - 6 * i +: 6])
                                                  : b64sc_pkg::PAD_CHAR;
                    n = n + 1;
                end
            end
        end else begin
            sx = char_sextet(b);
            if (!dec_halt) begin
                if (!sx[6]) begin
                    dec_halt = 1'b1;
                end else if (grp_cnt == 3) begin
                    word = {grp_bits, sx[5:0]};
                    for (int i = 0; i < 3; i++) begin
                        res[n] = word[16 - 8 * i +: 8];
                        n = n + 1;
                    end
                    grp_bits = '0;
                    grp_cnt  = '0;
                end else begin
                    grp_bits = {grp_bits[11:0], sx[5:0]};
                    grp_cnt  = grp_cnt + 2'd1;
                end
            end
            if (last && grp_cnt >= 2) begin
                word = {6'b0, grp_bits} << (6 * (4 - int'(grp_cnt)));
                for (int i = 0; i < int'(grp_cnt) - 1; i++) begin
                    res[n] = word[16 - 8 * i +: 8];
                    n = n + 1;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            o.data       = res[i];
            o.run_last   = (i == n - 1);
            o.stream_end = last && (i == n - 1);
            out_bytes_due.push_back(o);
        end
        if (last) begin
            grp_bits = '0;
            grp_cnt  = '0;
            dec_halt = 1'b0;
        end
    endtask

    always @(posedge aclk) begin : source_side
        in_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) b64_transcode(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (in_bytes_todo.size() > 0) begin
                    nxt = in_bytes_todo.pop_front();
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                    src_gap  <= draw_wait(src_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : sink_side
        out_req_t want;
        int       w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else if (m_tvalid && m_tready) begin
            if (out_bytes_due.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("unexpected byte %h last %b end %b", m_tdata, m_tlast, m_tuser[0]);
            end else begin
                want = out_bytes_due.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.run_last
                        || m_tuser[0] !== want.stream_end) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("mismatch: exp %h/%b/%b got %h/%b/%b", want.data,
                                 want.run_last, want.stream_end, m_tdata, m_tlast, m_tuser[0]);
                end
            end
            w = draw_wait(sink_calm);
            if (w > 0) begin
                m_tready <= 1'b0;
                sink_gap <= w;
            end
        end else if (!m_tready) begin
            if (sink_gap > 1) begin
                sink_gap <= sink_gap - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [7:0] b, input logic last);
        in_req_t r;
        r.data = b;
        r.last = last;
        in_bytes_todo.push_back(r);
    endtask

    task automatic send_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++) send(s[i], last && (i == s.len() - 1));
    endtask

    task automatic write_direction(input b64sc_pkg::dir_t d);
        @(posedge aclk);
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_dir  = d;
        grp_bits = '0;
        grp_cnt  = '0;
        dec_halt = 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        int spins;
        spins = 0;
        while ((in_bytes_todo.size() != 0 || s_tvalid || out_bytes_due.size() != 0)
                && spins < 20000) begin
            @(negedge aclk);
            spins++;
        end
        repeat (8) @(negedge aclk);
        if (out_bytes_due.size() != 0) begin
            errors = errors + out_bytes_due.size();
            if (errors <= 10) $display("%0d bytes never came out", out_bytes_due.size());
            out_bytes_due.delete();
        end
    endtask

    // one stream ending in tlast; returns the number of requests queued
    task automatic queue_stream(input b64sc_pkg::dir_t d, output int cnt);
        in_req_t q[$];
        in_req_t r;
        int      len;
        int      kind;
        int      stop_at;
        len  = $urandom_range(1, 12);
        kind = $urandom_range(0, 9);
        stop_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            r.last = 1'b0;
            if (d == b64sc_pkg::DIR_ENCODE || kind == 9 || (kind == 8 && i == stop_at))
                r.data = 8'($urandom_range(0, 255));
            else
                r.data = sextet_char(6'($urandom_range(0, 63)));
            q.push_back(r);
        end
        if (d == b64sc_pkg::DIR_DECODE && kind < 7) begin
            r.data = b64sc_pkg::PAD_CHAR;
            r.last = 1'b0;
            if (len % 4 >= 2) q.push_back(r);
            if (len % 4 == 2) q.push_back(r);
        end
        q[q.size() - 1].last = 1'b1;
        cnt = q.size();
        foreach (q[i]) in_bytes_todo.push_back(q[i]);
    endtask

    initial begin
        int              total;
        int              phase_items;
        int              cnt;
        b64sc_pkg::dir_t d;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_direction(b64sc_pkg::DIR_ENCODE);
        send(8'h00, 1'b1);
        send(8'hff, 1'b0);
        send(8'hff, 1'b1);
        send(8'h00, 1'b0);
        send(8'hff, 1'b0);
        send(8'h80, 1'b1);
        send(8'h5a, 1'b0);      // held pair, dropped by the next write
        send(8'ha5, 1'b0);
        settle();

        write_direction(b64sc_pkg::DIR_DECODE);
        send_text("/+9A", 1'b1);
        send_text("QUI=", 1'b1);
        send_text("Q", 1'b1);
        send_text("QU=Xz", 1'b1);
        send_text("AB", 1'b0);
        settle();
        write_direction(b64sc_pkg::DIR_DECODE);    // same value still drops the held sextets
        send_text("QQ", 1'b1);
        settle();

        total = 0;
        while (total < 120) begin
            d = b64sc_pkg::dir_t'($urandom_range(0, 1));
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            write_direction(d);
            phase_items = 0;
            while (phase_items < 30) begin
                queue_stream(d, cnt);
                phase_items += cnt;
            end
            if ($urandom_range(0, 3) == 0) begin
                cnt = $urandom_range(1, 3);
                for (int i = 0; i < cnt; i++)
                    send(d == b64sc_pkg::DIR_ENCODE ? 8'($urandom_range(0, 255))
                                                    : sextet_char(6'($urandom_range(0, 63))),
                         1'b0);
                phase_items += cnt;
            end
            total += phase_items;
            settle();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
